### hw/rtl/ir_heartbeat_detector_assert.svh
// Assertion macros used by the heartbeat detector checker.
`ifndef IR_HEARTBEAT_DETECTOR_ASSERT_SVH
`define IR_HEARTBEAT_DETECTOR_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define HBD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/hbd_pkg.sv
// Types, constants and filter coefficients of the heartbeat detector.
`default_nettype none

package hbd_pkg;

  localparam int RING_DEPTH_DEF = 32;

  localparam int IN_W    = 18;
  localparam int DATA_W  = 16;
  localparam int ACC_W   = 34;
  localparam int DIFF_W  = 35;
  localparam int DC_SHIFT = 15;
  localparam int DC_GAIN  = 4;
  localparam int FIR_ACC_W = 32;
  localparam int COEF_W  = 13;
  localparam int NUM_TAPS = 12;
  localparam int TAP_W   = 4;
  localparam int BACK_W  = 5;
  localparam int FIR_SPAN = 22;
  localparam int FIR_CENTER = 11;

  localparam logic [COEF_W-1:0] FIR_COEF [NUM_TAPS] = '{
    13'd172, 13'd321, 13'd579, 13'd927, 13'd1360, 13'd1858,
    13'd2390, 13'd2916, 13'd3391, 13'd3768, 13'd4012, 13'd4096
  };

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING_HIGH = 8'd1;

  localparam logic [DATA_W-1:0] SWING_LOW_RST  = 16'd20;
  localparam logic [DATA_W-1:0] SWING_HIGH_RST = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ACC,
    ST_EST,
    ST_FIR,
    ST_DONE
  } hbd_state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] din;
  } fir_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } fir_stat_t;

endpackage

`default_nettype wire

### hw/rtl/hbd_fir.sv
// Ring buffer and shared multiply-accumulate unit of the 23-tap low-pass filter.
`default_nettype none

module hbd_fir
  import hbd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fir_ctrl_t ctrl_i,
  output fir_stat_t stat_o
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW:0] DEPTH_V = (PW+1)'(RING_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(NUM_TAPS - 1);
  localparam logic [TAP_W-1:0] TAP_CENTER = TAP_W'(FIR_CENTER);
  localparam logic [BACK_W-1:0] SPAN_V = BACK_W'(FIR_SPAN);

  logic [DATA_W-1:0] mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q;

  logic [PW-1:0]    ptr_q;
  logic [TAP_W-1:0] tap_q;
  logic             issue_q;
  logic             rd_v_q, rd_last_q, pr_v_q, pr_last_q;
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [COEF_W-1:0] coef_q;
  logic             center_q;
  logic signed [30:0] prod_q;
  logic signed [FIR_ACC_W-1:0] acc_q;

  logic [PW-1:0] addr_a, addr_b;
  logic signed [DATA_W:0] pair;
  logic signed [30:0] prod_d;

  // Entry that lies a given number of samples behind the write pointer.
  function automatic logic [PW-1:0] back_idx(logic [PW-1:0] p, logic [BACK_W-1:0] back);
    logic [PW:0] pe;
    logic [PW:0] be;
    logic [PW:0] r;
    pe = {1'b0, p};
    be = (PW+1)'(back);
    if (pe >= be) begin
      r = pe - be;
    end else begin
      r = pe + DEPTH_V - be;
    end
    return r[PW-1:0];
  endfunction

  assign addr_a = back_idx(ptr_q, BACK_W'(tap_q));
  assign addr_b = back_idx(ptr_q, SPAN_V - BACK_W'(tap_q));

  // The center tap has no partner, so its second operand drops out.
  assign pair = $signed({rd_a_q[DATA_W-1], rd_a_q}) +
                (center_q ? 17'sd0 : $signed({rd_b_q[DATA_W-1], rd_b_q}));
  assign prod_d = pair * $signed({1'b0, coef_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mem[ptr_q] <= ctrl_i.din;
    end
    if (issue_q) begin
      rd_a_q   <= valid_q[addr_a] ? mem[addr_a] : '0;
      rd_b_q   <= valid_q[addr_b] ? mem[addr_b] : '0;
      coef_q   <= FIR_COEF[tap_q];
      center_q <= (tap_q == TAP_CENTER);
    end
    if (rd_v_q) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      ptr_q     <= '0;
      tap_q     <= '0;
      issue_q   <= 1'b0;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      pr_v_q    <= 1'b0;
      pr_last_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      rd_v_q    <= issue_q;
      rd_last_q <= issue_q && (tap_q == TAP_LAST);
      pr_v_q    <= rd_v_q;
      pr_last_q <= rd_last_q;
      if (ctrl_i.start) begin
        valid_q[ptr_q] <= 1'b1;
        tap_q   <= '0;
        issue_q <= 1'b1;
        acc_q   <= '0;
      end else begin
        if (issue_q) begin
          tap_q <= tap_q + 1'b1;
          if (tap_q == TAP_LAST) begin
            issue_q <= 1'b0;
          end
        end
        if (pr_v_q) begin
          acc_q <= acc_q + {prod_q[30], prod_q};
        end
      end
      if (pr_last_q) begin
        ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  assign stat_o.done   = pr_last_q;
  assign stat_o.result = acc_q[DC_SHIFT +: DATA_W];

endmodule

`default_nettype wire

### hw/rtl/ir_heartbeat_detector.sv
// Top level of the infrared heartbeat detector.
// Usage:
//   One raw sample enters per transaction on s_axis; one result leaves per
//   sample on m_axis. Swing limits are written on the cfg channel (index 0 is
//   the low limit, index 1 the high limit), which is always ready and should
//   only be written while no sample is in flight.
// Sequence:
//   After a sample is accepted, the DC tracker runs its difference and
//   accumulate steps, the corrected sample is written to the ring, then twelve
//   coefficient pairs pass through the single multiplier (one pair per cycle),
//   its read and product registers, and the sum goes to the output register.
//   s_axis_tready is low for the whole run, so no new sample is taken mid-run.
// Stalls:
//   The result sits in an output register; if it is still waiting at the end
//   of the next run, the block holds that run until m_axis_tready is seen.
// Reset:
//   Asynchronous, active low. It clears the DC tracker, ring pointer, ring
//   valid bits, peak tracking and restores the default swing limits.
`default_nettype none

module ir_heartbeat_detector
  import hbd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // [17:0] ir_sample, [23:18] zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,   // [0] beat_detected, [16:1] ac_value,
                                               // [32:17] dc_estimate, [39:33] zero
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  hbd_state_e state_q, state_d;

  logic [IN_W-1:0]          x_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [DATA_W-1:0]        lim_lo_q, lim_hi_q;
  logic signed [DATA_W-1:0] prev_q, max_q, min_q;
  logic                     rising_q, falling_q;
  logic                     m_valid_q;
  logic [39:0]              m_data_q;

  logic                     in_fire, out_load;
  logic signed [DIFF_W-1:0] diff_d;
  logic signed [ACC_W-1:0]  acc_d;
  logic [DATA_W-1:0]        est;
  fir_ctrl_t                fir_ctrl;
  fir_stat_t                fir_stat;

  logic signed [DATA_W-1:0] cur;
  logic                     pos_cross, neg_cross, beat;
  logic signed [DATA_W+1:0] swing;
  logic                     rising_d, falling_d;
  logic signed [DATA_W-1:0] max_d, min_d;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // DC tracker: acc += ((x << 15) - acc) >>> 4, kept to 34 bits.
  assign diff_d = $signed({2'b00, x_q, {DC_SHIFT{1'b0}}}) - $signed({acc_q[ACC_W-1], acc_q});
  assign acc_d  = acc_q + ACC_W'(diff_q >>> DC_GAIN);
  assign est    = acc_q[DC_SHIFT +: DATA_W];

  assign fir_ctrl.start = (state_q == ST_EST);
  assign fir_ctrl.din   = x_q[DATA_W-1:0] - est;

  hbd_fir #(
    .RING_DEPTH(RING_DEPTH)
  ) u_fir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fir_ctrl),
    .stat_o (fir_stat)
  );

  // Zero-crossing and peak tracking on the filtered sample.
  always_comb begin
    cur       = $signed(fir_stat.result);
    pos_cross = (prev_q < 0) && (cur >= 0);
    neg_cross = (prev_q > 0) && (cur <= 0);
    swing     = $signed({{2{max_q[DATA_W-1]}}, max_q}) -
                $signed({{2{min_q[DATA_W-1]}}, min_q});
    beat      = pos_cross &&
                (swing > $signed({2'b00, lim_lo_q})) &&
                (swing < $signed({2'b00, lim_hi_q}));
    rising_d  = rising_q;
    falling_d = falling_q;
    max_d     = max_q;
    min_d     = min_q;
    if (pos_cross) begin
      rising_d  = 1'b1;
      falling_d = 1'b0;
      max_d     = '0;
    end
    if (neg_cross) begin
      rising_d  = 1'b0;
      falling_d = 1'b1;
      min_d     = '0;
    end
    if (rising_d && (cur > prev_q)) begin
      max_d = cur;
    end
    if (falling_d && (cur < prev_q)) begin
      min_d = cur;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = (state_q == ST_IDLE);
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: state_d = ST_ACC;
      ST_ACC:  state_d = ST_EST;
      ST_EST:  state_d = ST_FIR;
      ST_FIR: begin
        if (fir_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= s_axis_tdata[IN_W-1:0];
    end
    if (state_q == ST_DIFF) begin
      diff_q <= diff_d;
    end
    if (out_load) begin
      m_data_q <= {7'd0, est, fir_stat.result, beat};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= '0;
      lim_lo_q  <= SWING_LOW_RST;
      lim_hi_q  <= SWING_HIGH_RST;
      prev_q    <= '0;
      max_q     <= '0;
      min_q     <= '0;
      rising_q  <= 1'b0;
      falling_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        acc_q <= acc_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SWING_LOW:  lim_lo_q <= cfg_data_i;
          CFG_SWING_HIGH: lim_hi_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        prev_q    <= cur;
        max_q     <= max_d;
        min_q     <= min_d;
        rising_q  <= rising_d;
        falling_q <= falling_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

### hw/rtl/hbd_checker.sv
// Port-level checks of the heartbeat detector, bound to its top level.
`default_nettype none
`include "ir_heartbeat_detector_assert.svh"

module hbd_checker
  import hbd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [39:0]          m_axis_tdata,
  input logic                 cfg_ready_o
);

  // A stalled result keeps its valid and its payload.
  `HBD_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `HBD_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")

  // The block is busy for the whole run after taking a sample.
  `HBD_ASSERT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "sample taken while busy")

  // A new result only appears at the end of a run, when input was blocked.
  `HBD_ASSERT(a_out_after_run, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without a run")

  // Configuration writes are never back-pressured.
  `HBD_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o, "configuration channel not ready")

endmodule

bind ir_heartbeat_detector hbd_checker u_hbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire
